### src/gpf_pkg.sv
// Shared types, codes and fixed-point constants of the Gram polynomial fit engine.
// Used by every module under src; depends on nothing.

package gpf_pkg;

    // Sizes of the fit
    localparam int MAX_POLYS  = 16;
    localparam int MAX_POINTS = 4096;
    localparam int FRAC_BITS  = 30;   // fraction bits of basis values and recurrence factors
    localparam int RECIP_FRAC = 20;   // fraction bits of the factor reciprocals
    localparam int INT_STEPS  = 16;   // root steps over the 32-bit integer part of a quotient

    // Field widths
    localparam int POLY_W = $clog2(MAX_POLYS);
    localparam int K_W    = 13;
    localparam int N_W    = 5;
    localparam int X_W    = 12;
    localparam int SMP_W  = 16;
    localparam int COEF_W = 48;
    localparam int TAB_W  = 32;
    localparam int PV_W   = 32;
    localparam int CFG_W  = 13;
    localparam int CIDX_W = 2;

    // Stream payload widths
    localparam int S_DATA_W = 80;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 48;
    localparam int M_USER_W = 1;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_NUM_POINTS = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_NUM_POLYS  = 2'd1;

    // Item modes as they arrive
    localparam logic [1:0] MODE_ACC = 2'd0;
    localparam logic [1:0] MODE_REC = 2'd1;
    localparam logic [1:0] MODE_WR  = 2'd2;
    localparam logic [1:0] MODE_RD  = 2'd3;

    // Item kinds after classification
    typedef logic [2:0] t_kind;
    localparam t_kind KIND_ACC = 3'd0;
    localparam t_kind KIND_REC = 3'd1;
    localparam t_kind KIND_WR  = 3'd2;
    localparam t_kind KIND_RD  = 3'd3;
    localparam t_kind KIND_RNG = 3'd4;

    // One classified item waiting for the back end
    typedef struct packed {
        t_kind                     kind;
        logic [X_W-1:0]            point;
        logic signed [SMP_W-1:0]   sample;
        logic [POLY_W-1:0]         cidx;
        logic signed [COEF_W-1:0]  cval;
    } t_item;

endpackage

### src/gpf_front.sv
// Front end: takes items from the input stream, classifies them and queues them.
// Depends on gpf_pkg.

module gpf_front
    import gpf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // point_index[11:0], sample_value[27:12], coef_index[31:28], coef_value[79:32]
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    // mode[1:0]
    input  logic [S_USER_W-1:0] s_axis_tuser,
    input  logic [K_W-1:0]      i_eff_k,
    output t_item               o_item,
    output logic                o_item_valid,
    input  logic                i_item_pop
);

    localparam int DEPTH = 2;

    t_item      r_q [DEPTH];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_item      w_item;
    logic       w_push;
    logic       w_pop;

    // Unpack and classify the incoming item
    always_comb begin
        w_item.point  = s_axis_tdata[11:0];
        w_item.sample = s_axis_tdata[27:12];
        w_item.cidx   = s_axis_tdata[31:28];
        w_item.cval   = s_axis_tdata[79:32];
        case (s_axis_tuser)
            MODE_WR: w_item.kind = KIND_WR;
            MODE_RD: w_item.kind = KIND_RD;
            MODE_ACC: begin
                w_item.kind = ({1'b0, w_item.point} >= i_eff_k) ? KIND_RNG : KIND_ACC;
            end
            MODE_REC: begin
                w_item.kind = ({1'b0, w_item.point} >= i_eff_k) ? KIND_RNG : KIND_REC;
            end
            default: w_item.kind = KIND_RNG;
        endcase
    end

    assign s_axis_tready = (r_cnt != 2'(DEPTH));
    assign w_push        = s_axis_tvalid && s_axis_tready;
    assign w_pop         = i_item_pop && o_item_valid;
    assign o_item_valid  = (r_cnt != 2'd0);
    assign o_item        = r_q[r_rp];

    // Advance the queue pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    // Hold queued items
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
    end

endmodule

### src/gpf_tables.sv
// Configuration registers and the recurrence factor tables, rebuilt by a
// serial divider feeding a digit-by-digit square root. Depends on gpf_pkg.

module gpf_tables
    import gpf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    output logic [K_W-1:0]    o_eff_k,
    output logic [N_W-1:0]    o_eff_n,
    output logic              o_ready,
    input  logic [POLY_W-1:0] i_a_idx,
    output logic [TAB_W-1:0]  o_a_val,
    input  logic [POLY_W-1:0] i_r_idx,
    output logic [TAB_W-1:0]  o_r_val
);

    localparam logic [1:0] TB_SETUP1 = 2'd0;
    localparam logic [1:0] TB_SETUP2 = 2'd1;
    localparam logic [1:0] TB_RUN    = 2'd2;
    localparam logic [1:0] TB_DONE   = 2'd3;
    localparam logic [5:0] LAST_A    = 6'(INT_STEPS + FRAC_BITS - 1);
    localparam logic [5:0] LAST_R    = 6'(INT_STEPS + RECIP_FRAC - 1);

    logic [K_W-1:0]    r_num_points;
    logic [N_W-1:0]    r_num_polys;
    logic [1:0]        r_state;
    logic [POLY_W-1:0] r_ti;
    logic              r_tr;
    logic [5:0]        r_step;
    logic [25:0]       r_kk;
    logic [7:0]        r_ii;
    logic [31:0]       r_div;
    logic [31:0]       r_dvd;
    logic [31:0]       r_drem;
    logic [32:0]       r_root;
    logic [33:0]       r_rrem;
    logic [TAB_W-1:0]  r_a_tab [MAX_POLYS];
    logic [TAB_W-1:0]  r_r_tab [MAX_POLYS];

    logic [N_W-1:0]    w_n1;
    logic [33:0]       w_den_full;
    logic [31:0]       w_num_a, w_den_a;
    logic [32:0]       w_rr1, w_rr2;
    logic              w_ge1, w_ge2, w_gr;
    logic [31:0]       w_rem1, w_rem2;
    logic [35:0]       w_rq;
    logic [34:0]       w_t;
    logic [33:0]       n_rrem;
    logic [32:0]       n_root;
    logic              w_last;
    logic [N_W-1:0]    w_ti_next;

    // Clamp the configured counts
    always_comb begin
        if (r_num_points < K_W'(2))               o_eff_k = K_W'(2);
        else if (r_num_points > K_W'(MAX_POINTS)) o_eff_k = K_W'(MAX_POINTS);
        else                                      o_eff_k = r_num_points;
        if (r_num_polys == '0)                    w_n1 = N_W'(1);
        else if (r_num_polys > N_W'(MAX_POLYS))   w_n1 = N_W'(MAX_POLYS);
        else                                      w_n1 = r_num_polys;
        o_eff_n = ({{(K_W-N_W){1'b0}}, w_n1} > o_eff_k) ? N_W'(o_eff_k) : w_n1;
    end

    // Numerator and denominator of the squared factor
    always_comb begin
        w_den_full = 34'(r_ii) * (34'(r_kk) - 34'(r_ii));
        if (r_ti == '0) begin
            w_num_a = 32'd1;
            w_den_a = 32'(o_eff_k);
        end else begin
            w_num_a = 32'({r_ii, 2'b00}) - 32'd1;
            w_den_a = w_den_full[31:0];
        end
    end

    // Two quotient bits and one root digit per cycle
    always_comb begin
        w_rr1  = {r_drem, r_dvd[31]};
        w_ge1  = (w_rr1 >= {1'b0, r_div});
        w_rem1 = w_ge1 ? 32'(w_rr1 - {1'b0, r_div}) : w_rr1[31:0];
        w_rr2  = {w_rem1, r_dvd[30]};
        w_ge2  = (w_rr2 >= {1'b0, r_div});
        w_rem2 = w_ge2 ? 32'(w_rr2 - {1'b0, r_div}) : w_rr2[31:0];
        w_rq   = {r_rrem, w_ge1, w_ge2};
        w_t    = {r_root, 2'b01};
        w_gr   = (w_rq >= {1'b0, w_t});
        n_rrem = w_gr ? 34'(w_rq - {1'b0, w_t}) : w_rq[33:0];
        n_root = {r_root[31:0], w_gr};
        w_last = (r_step == (r_tr ? LAST_R : LAST_A));
        w_ti_next = {1'b0, r_ti} + N_W'(1);
    end

    // Sequence the table build; restart it on every register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_points <= K_W'(16);
            r_num_polys  <= N_W'(4);
            r_state      <= TB_SETUP1;
            r_ti         <= '0;
            r_tr         <= 1'b0;
            r_step       <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == CFG_NUM_POINTS) r_num_points <= i_cfg_wdata;
            if (i_cfg_addr == CFG_NUM_POLYS)  r_num_polys  <= i_cfg_wdata[N_W-1:0];
            if (i_cfg_addr == CFG_NUM_POINTS || i_cfg_addr == CFG_NUM_POLYS) begin
                r_state <= TB_SETUP1;
                r_ti    <= '0;
                r_tr    <= 1'b0;
            end
        end else begin
            case (r_state)
                TB_SETUP1: r_state <= TB_SETUP2;
                TB_SETUP2: begin
                    r_state <= TB_RUN;
                    r_step  <= '0;
                end
                TB_RUN: begin
                    r_step <= r_step + 6'd1;
                    if (w_last) begin
                        if (r_ti == '0) begin
                            if (o_eff_n > N_W'(1)) begin
                                r_ti    <= POLY_W'(1);
                                r_state <= TB_SETUP1;
                            end else begin
                                r_state <= TB_DONE;
                            end
                        end else if (!r_tr) begin
                            r_tr    <= 1'b1;
                            r_state <= TB_SETUP1;
                        end else if (w_ti_next < o_eff_n) begin
                            r_ti    <= w_ti_next[POLY_W-1:0];
                            r_tr    <= 1'b0;
                            r_state <= TB_SETUP1;
                        end else begin
                            r_state <= TB_DONE;
                        end
                    end
                end
                TB_DONE: r_state <= TB_DONE;
                default: r_state <= TB_SETUP1;
            endcase
        end
    end

    // Datapath of the divider and root
    always_ff @(posedge i_clk) begin
        case (r_state)
            TB_SETUP1: begin
                r_kk <= 26'(o_eff_k) * 26'(o_eff_k);
                r_ii <= 8'(r_ti) * 8'(r_ti);
            end
            TB_SETUP2: begin
                r_dvd  <= r_tr ? w_den_a : w_num_a;
                r_div  <= r_tr ? w_num_a : w_den_a;
                r_drem <= '0;
                r_root <= '0;
                r_rrem <= '0;
            end
            TB_RUN: begin
                r_dvd  <= {r_dvd[29:0], 2'b00};
                r_drem <= w_rem2;
                r_root <= n_root;
                r_rrem <= n_rrem;
                if (w_last) begin
                    if (r_tr) r_r_tab[r_ti] <= n_root[TAB_W-1:0];
                    else      r_a_tab[r_ti] <= n_root[TAB_W-1:0];
                end
            end
            default: r_root <= r_root;
        endcase
    end

    assign o_ready = (r_state == TB_DONE);
    assign o_a_val = r_a_tab[i_a_idx];
    assign o_r_val = r_r_tab[i_r_idx];

endmodule

### src/gpf_back.sv
// Back end: runs the basis recurrence on one shared 24x33 multiplier, updates
// the coefficient store and drives the output register. Depends on gpf_pkg.

module gpf_back
    import gpf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_item               i_item,
    input  logic                i_item_valid,
    output logic                o_item_pop,
    input  logic                i_ready,
    input  logic [K_W-1:0]      i_eff_k,
    input  logic [N_W-1:0]      i_eff_n,
    output logic [POLY_W-1:0]   o_a_idx,
    input  logic [TAB_W-1:0]    i_a_val,
    output logic [POLY_W-1:0]   o_r_idx,
    input  logic [TAB_W-1:0]    i_r_val,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // result_value[47:0]
    output logic [M_DATA_W-1:0] m_axis_tdata,
    // range_error[0]
    output logic [M_USER_W-1:0] m_axis_tuser
);

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_SEL  = 3'd1;
    localparam logic [2:0] B_LO   = 3'd2;
    localparam logic [2:0] B_HI   = 3'd3;
    localparam logic [2:0] B_WB   = 3'd4;
    localparam logic [2:0] B_OUT  = 3'd5;

    localparam logic [2:0] OP_A01 = 3'd0;  // a0 * a1
    localparam logic [2:0] OP_P1  = 3'd1;  // P1 from a0*a1 and p
    localparam logic [2:0] OP_M1  = 3'd2;  // p * P(i-1)
    localparam logic [2:0] OP_M2  = 3'd3;  // P(i-2) * r(i-1)
    localparam logic [2:0] OP_PN  = 3'd4;  // a(i) * difference
    localparam logic [2:0] OP_USE = 3'd5;  // accumulate or reconstruct term

    localparam logic [1:0] SH_0  = 2'd0;
    localparam logic [1:0] SH_14 = 2'd1;
    localparam logic [1:0] SH_20 = 2'd2;
    localparam logic [1:0] SH_30 = 2'd3;

    localparam logic [60:0] PROD_LIM = '1;

    logic [2:0]               r_state, r_op;
    logic [POLY_W-1:0]        r_i;
    logic                     r_rec;
    logic signed [13:0]       r_p;
    logic signed [SMP_W-1:0]  r_sample;
    logic signed [PV_W-1:0]   r_pvc, r_pv1, r_pv2;
    logic signed [47:0]       r_u, r_t;
    logic signed [62:0]       r_m1;
    logic signed [53:0]       r_acc;
    logic signed [COEF_W-1:0] r_res;
    logic                     r_err;
    logic [47:0]              r_mag_a;
    logic [32:0]              r_mag_b;
    logic                     r_neg;
    logic [1:0]               r_shift;
    logic [56:0]              r_pp;
    logic [80:0]              r_prod;
    logic signed [COEF_W-1:0] r_coef [MAX_POLYS];
    logic                     r_ovalid;
    logic [M_DATA_W-1:0]      r_odata;
    logic                     r_ouser;

    logic [POLY_W-1:0]        w_cidx;
    logic signed [COEF_W-1:0] w_coef_rd;
    logic signed [47:0]       w_opa;
    logic signed [32:0]       w_opb;
    logic [1:0]               w_sh;
    logic [80:0]              w_shifted;
    logic [60:0]              w_mag;
    logic signed [62:0]       w_res;
    logic signed [63:0]       w_csum;
    logic signed [53:0]       w_acc_next;
    logic signed [14:0]       w_p;
    logic                     w_last_poly;
    logic                     w_out_free;

    function automatic logic signed [PV_W-1:0] sat_pv(input logic signed [62:0] v);
        if (v > 63'sd2147483647)       return 32'sh7FFFFFFF;
        else if (v < -63'sd2147483648) return 32'sh80000000;
        else                           return v[PV_W-1:0];
    endfunction

    function automatic logic signed [COEF_W-1:0] sat_coef(input logic signed [63:0] v);
        if (v > 64'sh00007FFFFFFFFFFF)      return 48'sh7FFFFFFFFFFF;
        else if (v < -64'sh0000800000000000) return 48'sh800000000000;
        else                                return v[COEF_W-1:0];
    endfunction

    // Table and store read addresses, item pop, point offset and loop and output conditions
    assign w_cidx    = (r_state == B_IDLE) ? i_item.cidx : r_i;
    assign w_coef_rd = r_coef[w_cidx];
    assign o_a_idx   = (r_state == B_IDLE) ? '0 : r_i;
    assign o_r_idx   = r_i - POLY_W'(1);
    assign o_item_pop = (r_state == B_IDLE) && i_item_valid && i_ready;
    assign w_p = $signed({2'b00, i_item.point, 1'b0}) - $signed({2'b00, i_eff_k}) + 15'sd1;
    assign w_last_poly = (({1'b0, r_i} + N_W'(1)) == i_eff_n);
    assign w_out_free  = !r_ovalid || m_axis_tready;

    // Select multiplier operands for the current step
    always_comb begin
        w_opa = '0;
        w_opb = '0;
        w_sh  = SH_0;
        case (r_op)
            OP_A01: begin
                w_opa = 48'(r_pv1);
                w_opb = $signed({1'b0, i_a_val});
                w_sh  = SH_30;
            end
            OP_P1: begin
                w_opa = r_u;
                w_opb = 33'(r_p);
            end
            OP_M1: begin
                w_opa = 48'(r_pv1);
                w_opb = 33'(r_p);
            end
            OP_M2: begin
                w_opa = 48'(r_pv2);
                w_opb = $signed({1'b0, i_r_val});
                w_sh  = SH_20;
            end
            OP_PN: begin
                w_opa = r_t;
                w_opb = $signed({1'b0, i_a_val});
                w_sh  = SH_30;
            end
            OP_USE: begin
                if (r_rec) begin
                    w_opa = w_coef_rd;
                    w_opb = 33'(r_pvc);
                    w_sh  = SH_30;
                end else begin
                    w_opa = 48'(r_pvc);
                    w_opb = 33'(r_sample);
                    w_sh  = SH_14;
                end
            end
            default: w_sh = SH_0;
        endcase
    end

    // Scale, clamp and sign the finished product; form the store and accumulator sums
    always_comb begin
        case (r_shift)
            SH_0:    w_shifted = r_prod;
            SH_14:   w_shifted = r_prod >> 14;
            SH_20:   w_shifted = r_prod >> RECIP_FRAC;
            SH_30:   w_shifted = r_prod >> FRAC_BITS;
            default: w_shifted = r_prod;
        endcase
        w_mag      = (w_shifted[80:61] != '0) ? PROD_LIM : w_shifted[60:0];
        w_res      = r_neg ? -$signed({2'b00, w_mag}) : $signed({2'b00, w_mag});
        w_csum     = 64'(w_coef_rd) + 64'(w_res);
        w_acc_next = r_acc + w_res[53:0];
    end

    // Sequence items through the recurrence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_op     <= OP_USE;
            r_i      <= '0;
            for (int j = 0; j < MAX_POLYS; j++) r_coef[j] <= '0;
        end else begin
            case (r_state)
                B_IDLE: begin
                    if (o_item_pop) begin
                        case (i_item.kind)
                            KIND_WR: r_coef[i_item.cidx] <= i_item.cval;
                            KIND_RD: begin
                                r_res   <= w_coef_rd;
                                r_err   <= 1'b0;
                                r_state <= B_OUT;
                            end
                            KIND_RNG: begin
                                r_res   <= '0;
                                r_err   <= 1'b1;
                                r_state <= B_OUT;
                            end
                            KIND_ACC, KIND_REC: begin
                                r_rec    <= (i_item.kind == KIND_REC);
                                r_p      <= w_p[13:0];
                                r_sample <= i_item.sample;
                                r_pvc    <= sat_pv(63'($signed({1'b0, i_a_val})));
                                r_i      <= '0;
                                r_acc    <= '0;
                                r_op     <= OP_USE;
                                r_state  <= B_SEL;
                            end
                            default: r_state <= B_IDLE;
                        endcase
                    end
                end
                B_SEL: begin
                    r_neg   <= w_opa[47] ^ w_opb[32];
                    r_mag_a <= w_opa[47] ? 48'(-w_opa) : w_opa;
                    r_mag_b <= w_opb[32] ? 33'(-w_opb) : w_opb;
                    r_shift <= w_sh;
                    r_state <= B_LO;
                end
                B_LO: begin
                    r_pp    <= 57'(r_mag_a[23:0]) * 57'(r_mag_b);
                    r_state <= B_HI;
                end
                B_HI: begin
                    r_prod  <= {24'b0, r_pp} + {57'(r_mag_a[47:24]) * 57'(r_mag_b), 24'b0};
                    r_state <= B_WB;
                end
                B_WB: begin
                    case (r_op)
                        OP_A01: begin
                            r_u     <= w_res[47:0];
                            r_op    <= OP_P1;
                            r_state <= B_SEL;
                        end
                        OP_P1: begin
                            r_pvc   <= sat_pv(w_res);
                            r_op    <= OP_USE;
                            r_state <= B_SEL;
                        end
                        OP_M1: begin
                            r_m1    <= w_res;
                            r_op    <= OP_M2;
                            r_state <= B_SEL;
                        end
                        OP_M2: begin
                            r_t     <= 48'(r_m1 - w_res);
                            r_op    <= OP_PN;
                            r_state <= B_SEL;
                        end
                        OP_PN: begin
                            r_pvc   <= sat_pv(w_res);
                            r_op    <= OP_USE;
                            r_state <= B_SEL;
                        end
                        OP_USE: begin
                            if (!r_rec) r_coef[r_i] <= sat_coef(w_csum);
                            r_acc <= w_acc_next;
                            if (w_last_poly) begin
                                if (r_rec) begin
                                    r_res   <= sat_coef(64'(w_acc_next));
                                    r_err   <= 1'b0;
                                    r_state <= B_OUT;
                                end else begin
                                    r_state <= B_IDLE;
                                end
                            end else begin
                                r_i     <= r_i + POLY_W'(1);
                                r_pv2   <= r_pv1;
                                r_pv1   <= r_pvc;
                                r_op    <= (r_i == '0) ? OP_A01 : OP_M1;
                                r_state <= B_SEL;
                            end
                        end
                        default: r_state <= B_IDLE;
                    endcase
                end
                B_OUT: begin
                    if (w_out_free) begin
                        r_odata  <= r_res;
                        r_ouser  <= r_err;
                        r_state  <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    // Raise the output valid on a new result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == B_OUT && w_out_free) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tvalid && m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

endmodule

### src/gram_polynomial_fit_engine.sv
// Top level of the Gram polynomial fit engine: front queue, factor tables, back end.
// Depends on gpf_pkg, gpf_front, gpf_tables and gpf_back.

// Fits samples on k equally spaced points to n orthonormal Gram polynomials.
// Mode 0 adds sample times each basis value into the coefficient store, mode 1
// rebuilds a sample from the store, modes 2 and 3 write and read one slot; in
// modes 0 and 1 a point at or beyond k gives result 0 with range_error set.
// Modes 0 and 1 run the three-term recurrence on one shared multiplier whose
// every step passes through operand select, low partial product, high partial
// product and write-back. After reset and after each register write the
// factor tables rebuild through a serial divider and root; items queue
// meanwhile and start once the tables are ready. A two-entry queue takes
// items while the back end works or waits on the output.

module gram_polynomial_fit_engine
    import gpf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // point_index[11:0], sample_value[27:12], coef_index[31:28], coef_value[79:32]
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    // mode[1:0]
    input  logic [S_USER_W-1:0] s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // result_value[47:0]
    output logic [M_DATA_W-1:0] m_axis_tdata,
    // range_error[0]
    output logic [M_USER_W-1:0] m_axis_tuser,
    input  logic                i_cfg_we,
    input  logic [CIDX_W-1:0]   i_cfg_addr,
    input  logic [CFG_W-1:0]    i_cfg_wdata
);

    t_item             w_item;
    logic              w_item_valid;
    logic              w_item_pop;
    logic [K_W-1:0]    w_eff_k;
    logic [N_W-1:0]    w_eff_n;
    logic              w_ready;
    logic [POLY_W-1:0] w_a_idx, w_r_idx;
    logic [TAB_W-1:0]  w_a_val, w_r_val;

    gpf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .i_eff_k      (w_eff_k),
        .o_item       (w_item),
        .o_item_valid (w_item_valid),
        .i_item_pop   (w_item_pop)
    );

    gpf_tables u_tables (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata),
        .o_eff_k    (w_eff_k),
        .o_eff_n    (w_eff_n),
        .o_ready    (w_ready),
        .i_a_idx    (w_a_idx),
        .o_a_val    (w_a_val),
        .i_r_idx    (w_r_idx),
        .o_r_val    (w_r_val)
    );

    gpf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (w_item),
        .i_item_valid (w_item_valid),
        .o_item_pop   (w_item_pop),
        .i_ready      (w_ready),
        .i_eff_k      (w_eff_k),
        .i_eff_n      (w_eff_n),
        .o_a_idx      (w_a_idx),
        .i_a_val      (w_a_val),
        .o_r_idx      (w_r_idx),
        .i_r_val      (w_r_val),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

endmodule

### src/gpf_checker.sv
// Port-level checks of the Gram polynomial fit engine, bound to the top level.
// Depends on gpf_pkg and gram_polynomial_fit_engine.

module gpf_checker
    import gpf_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                s_axis_tready,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [M_DATA_W-1:0] m_axis_tdata,
    input logic [M_USER_W-1:0] m_axis_tuser
);

    // Queue is empty and open right after reset
    a_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready)
        else $error("input not ready after reset");

    // No result right after reset
    a_no_out_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result shown right after reset");

    // An out-of-range result carries a zero value
    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("range error with nonzero value");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind gram_polynomial_fit_engine gpf_checker u_gpf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
);
